### rtl/core/ssrd_pkg.sv
// Shared types and constants of the swing support/resistance detector.
package ssrd_pkg;

    localparam int unsigned PRICE_W = 32;
    localparam int unsigned KIND_W  = 2;

    // Event codes carried on the result channel
    localparam logic [KIND_W-1:0] EV_NONE       = 2'd0;
    localparam logic [KIND_W-1:0] EV_SUPPORT    = 2'd1;
    localparam logic [KIND_W-1:0] EV_RESISTANCE = 2'd2;

    // Least common multiple of 1..k for k = 1..16, indexed by k-1
    localparam int unsigned LCM_TABLE [16] = '{
        1, 2, 6, 12, 60, 60, 420, 840, 2520, 2520,
        27720, 27720, 360360, 360360, 360360, 720720
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SLOPE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic slope;
        logic search;
        logic publish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic search_done;
        logic out_free;
    } status_t;

endpackage

### rtl/core/ssrd_ctrl.sv
// Sequencing controller of the swing support/resistance detector.
module ssrd_ctrl
    import ssrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SLOPE;
            end
            ST_SLOPE:
            begin
                cmd.slope  = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/ssrd_datapath.sv
// Datapath: candle windows, scaled moving average, slope sum and level search.
module ssrd_datapath
    import ssrd_pkg::*;
#(
    parameter int unsigned SEARCH_DEPTH   = 10,
    parameter int unsigned AVERAGE_LENGTH = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [PRICE_W-1:0] open_price,
    input  logic [PRICE_W-1:0] close_price,
    input  logic [PRICE_W-1:0] candle_time,
    input  cmd_t               cmd,
    output status_t            status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  event_kind,
    output logic [PRICE_W-1:0] level_price,
    output logic [PRICE_W-1:0] level_time
);

    localparam int unsigned SCALE = LCM_TABLE[AVERAGE_LENGTH-1];
    localparam int unsigned FW    = $clog2(SCALE + 1);
    localparam int unsigned SW    = PRICE_W + $clog2(AVERAGE_LENGTH);
    localparam int unsigned AW    = PRICE_W + FW;
    localparam int unsigned DW    = AW + 1;
    localparam int unsigned LO_W  = (SW + 1) / 2;
    localparam int unsigned HI_W  = SW - LO_W;
    localparam int unsigned PW    = SW + FW;
    localparam int unsigned CAP_A = (SEARCH_DEPTH > AVERAGE_LENGTH) ? SEARCH_DEPTH
                                                                    : AVERAGE_LENGTH;
    localparam int unsigned CAP   = (CAP_A > 3) ? CAP_A : 3;
    localparam int unsigned CW    = $clog2(CAP + 1);
    localparam int unsigned DPW   = $clog2(SEARCH_DEPTH + 1);
    localparam int unsigned PTRW  = $clog2(SEARCH_DEPTH);
    localparam int unsigned NAVW  = $clog2(AVERAGE_LENGTH);
    localparam int unsigned MEM_W = 3 * PRICE_W;

    // Scale factor per point count: SCALE / k for k = 1..AVERAGE_LENGTH
    logic [FW-1:0] factor_tab [AVERAGE_LENGTH];
    for (genvar k = 0; k < AVERAGE_LENGTH; k++)
    begin : g_factor
        localparam int unsigned FACTOR = SCALE / (k + 1);
        assign factor_tab[k] = FW'(FACTOR);
    end

    function automatic logic [PTRW-1:0] ptr_inc(input logic [PTRW-1:0] p);
        ptr_inc = (p == PTRW'(SEARCH_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTRW-1:0] ptr_dec(input logic [PTRW-1:0] p);
        ptr_dec = (p == '0) ? PTRW'(SEARCH_DEPTH - 1) : p - 1'b1;
    endfunction

    // Control registers
    logic [CW-1:0]   seen_reg;
    logic            ge1_reg;
    logic            ge2_reg;
    logic [PTRW-1:0] wptr_reg;
    logic [PTRW-1:0] rd_ptr_reg;
    logic [PTRW-1:0] remain_reg;
    logic            rd_valid_reg;
    logic            up_reg;
    logic            down_reg;
    logic            out_valid_reg;

    // Running state of the averages
    logic [PRICE_W-1:0]   close_win_reg [AVERAGE_LENGTH];
    logic [SW-1:0]        close_sum_reg;
    logic [AW-1:0]        last_avg_reg;
    logic signed [DW-1:0] slope_win_reg [AVERAGE_LENGTH];
    logic signed [DW-1:0] slope_sum_reg;

    // Payload registers
    logic [PRICE_W-1:0] top_reg;
    logic [PRICE_W-1:0] bot_reg;
    logic [PRICE_W-1:0] time_reg;
    logic [FW-1:0]      factor_reg;
    logic [DPW-1:0]     depth_reg;
    logic [PW-1:0]      acc_reg;
    logic [PRICE_W-1:0] best_price_reg;
    logic [PRICE_W-1:0] best_time_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [PRICE_W-1:0] price_out_reg;
    logic [PRICE_W-1:0] time_out_reg;

    // Candle window memory, one word {time, bottom, top} per candle
    logic [MEM_W-1:0] mem [SEARCH_DEPTH];
    logic [MEM_W-1:0] rd_data_reg;

    // Load-time values
    logic [CW-1:0]      n_next;
    logic [NAVW-1:0]    fac_idx;
    logic [DPW-1:0]     depth_next;
    logic [PRICE_W-1:0] body_top;
    logic [PRICE_W-1:0] body_bot;
    logic [SW-1:0]      close_sum_next;
    logic [PTRW-1:0]    wptr_next;

    // Multiplier partial products
    logic [LO_W+FW-1:0] prod_lo;
    logic [HI_W+FW-1:0] prod_hi;

    // Slope values
    logic [AW-1:0]        scaled;
    logic signed [DW-1:0] diff;
    logic signed [DW-1:0] slope_next;
    logic                 up_next;
    logic                 down_next;

    // Search compare
    logic [PRICE_W-1:0] mem_top;
    logic [PRICE_W-1:0] mem_bot;
    logic [PRICE_W-1:0] mem_time;
    logic               better;

    // Candle intake
    always_comb
    begin
        n_next         = (seen_reg == CW'(CAP)) ? seen_reg : seen_reg + 1'b1;
        fac_idx        = (n_next < AVERAGE_LENGTH) ? NAVW'(n_next - 1'b1)
                                                   : NAVW'(AVERAGE_LENGTH - 1);
        depth_next     = (n_next < SEARCH_DEPTH) ? DPW'(n_next) : DPW'(SEARCH_DEPTH);
        body_top       = (close_price <= open_price) ? open_price : close_price;
        body_bot       = (close_price <= open_price) ? close_price : open_price;
        close_sum_next = close_sum_reg + SW'(close_price)
                         - SW'(close_win_reg[AVERAGE_LENGTH-1]);
        wptr_next      = ptr_inc(wptr_reg);
    end

    // Scaled average in two partial products
    assign prod_lo = close_sum_reg[LO_W-1:0] * factor_reg;
    assign prod_hi = close_sum_reg[SW-1:LO_W] * factor_reg;

    // Slope sum and sign change
    always_comb
    begin
        scaled     = acc_reg[AW-1:0];
        diff       = signed'(DW'(scaled)) - signed'(DW'(last_avg_reg));
        slope_next = slope_sum_reg + diff - slope_win_reg[AVERAGE_LENGTH-1];
        up_next    = ge2_reg && slope_sum_reg[DW-1]
                     && !slope_next[DW-1] && (slope_next != '0);
        down_next  = ge2_reg && !slope_sum_reg[DW-1] && (slope_sum_reg != '0)
                     && slope_next[DW-1];
    end

    // Candidate from memory against the running best; strict, so newer wins ties
    always_comb
    begin
        mem_top  = rd_data_reg[PRICE_W-1:0];
        mem_bot  = rd_data_reg[2*PRICE_W-1:PRICE_W];
        mem_time = rd_data_reg[3*PRICE_W-1:2*PRICE_W];
        better   = up_reg ? (mem_bot < best_price_reg) : (mem_top > best_price_reg);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            ge1_reg       <= 1'b0;
            ge2_reg       <= 1'b0;
            wptr_reg      <= '0;
            rd_ptr_reg    <= '0;
            remain_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            up_reg        <= 1'b0;
            down_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                seen_reg <= n_next;
                ge1_reg  <= (seen_reg >= 1);
                ge2_reg  <= (seen_reg >= 2);
                wptr_reg <= wptr_next;
            end
            if (cmd.slope)
            begin
                up_reg     <= up_next;
                down_reg   <= down_next;
                rd_ptr_reg <= ptr_dec(wptr_reg);
                remain_reg <= (up_next || down_next) ? PTRW'(depth_reg - 1'b1) : '0;
            end
            if (cmd.search && (remain_reg != '0))
            begin
                rd_valid_reg <= 1'b1;
                rd_ptr_reg   <= ptr_dec(rd_ptr_reg);
                remain_reg   <= remain_reg - 1'b1;
            end
            else
            begin
                rd_valid_reg <= 1'b0;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Average and slope windows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AVERAGE_LENGTH; i++)
            begin
                close_win_reg[i] <= '0;
                slope_win_reg[i] <= '0;
            end
            close_sum_reg <= '0;
            last_avg_reg  <= '0;
            slope_sum_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = AVERAGE_LENGTH - 1; i > 0; i--)
                begin
                    close_win_reg[i] <= close_win_reg[i-1];
                end
                close_win_reg[0] <= close_price;
                close_sum_reg    <= close_sum_next;
            end
            if (cmd.slope)
            begin
                last_avg_reg <= scaled;
                if (ge1_reg)
                begin
                    for (int i = AVERAGE_LENGTH - 1; i > 0; i--)
                    begin
                        slope_win_reg[i] <= slope_win_reg[i-1];
                    end
                    slope_win_reg[0] <= diff;
                    slope_sum_reg    <= slope_next;
                end
            end
        end
    end

    // Payload path
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            top_reg    <= body_top;
            bot_reg    <= body_bot;
            time_reg   <= candle_time;
            factor_reg <= factor_tab[fac_idx];
            depth_reg  <= depth_next;
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= PW'(prod_lo);
        end
        else if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + (PW'(prod_hi) << LO_W);
        end
        if (cmd.slope)
        begin
            best_price_reg <= up_next ? bot_reg : top_reg;
            best_time_reg  <= time_reg;
        end
        else if (rd_valid_reg && better)
        begin
            best_price_reg <= up_reg ? mem_bot : mem_top;
            best_time_reg  <= mem_time;
        end
        if (cmd.publish)
        begin
            kind_reg      <= up_reg ? EV_SUPPORT : (down_reg ? EV_RESISTANCE : EV_NONE);
            price_out_reg <= (up_reg || down_reg) ? best_price_reg : '0;
            time_out_reg  <= (up_reg || down_reg) ? best_time_reg : '0;
        end
    end

    // Window memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[wptr_next] <= {candle_time, body_bot, body_top};
        end
        rd_data_reg <= mem[rd_ptr_reg];
    end

    assign status.search_done = (remain_reg == '0) && !rd_valid_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign event_kind  = kind_reg;
    assign level_price = price_out_reg;
    assign level_time  = time_out_reg;

endmodule

### rtl/core/swing_support_resistance_detector_core.sv
// Top level of the swing support/resistance detector.
//
// Channel  Dir  Transaction
// s_*      in   one closed candle: open_price, close_price, candle_time
// m_*      out  one result per candle: event_kind, level_price, level_time
//
// One candle is taken at a time. After acceptance the controller steps through
// ST_MUL_LO, ST_MUL_HI, ST_SLOPE and ST_SEARCH to ST_DONE; when a level is
// searched, ST_SEARCH scans the older depth - 1 entries of the candle window
// memory one entry a cycle, where depth is min(candles seen, SEARCH_DEPTH). The
// result register loads in ST_DONE as the controller returns to ST_IDLE for the next candle.
// Reset clears the average and slope windows, sums and counters; the candle
// memory needs no clearing pass, since the scan never reaches unwritten entries.
// A result waiting on m_tready does not block the next candle; only the
// following result waits for the output register to empty.
module swing_support_resistance_detector_core
    import ssrd_pkg::*;
#(
    parameter int unsigned SEARCH_DEPTH   = 10,
    parameter int unsigned AVERAGE_LENGTH = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // open_price, close_price, candle_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // level_price, level_time
    output logic [1:0]  m_tuser    // event_kind
);

    cmd_t    cmd;
    status_t status;

    ssrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssrd_datapath #(
        .SEARCH_DEPTH   (SEARCH_DEPTH),
        .AVERAGE_LENGTH (AVERAGE_LENGTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .open_price  (s_tdata[31:0]),
        .close_price (s_tdata[63:32]),
        .candle_time (s_tdata[95:64]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .event_kind  (m_tuser),
        .level_price (m_tdata[31:0]),
        .level_time  (m_tdata[63:32])
    );

    // One candle in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a candle is in flight");

    // A new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // No event carries no level
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_NONE)) |-> (m_tdata == '0))
        else $error("level present without an event");

endmodule

### sim/swing_support_resistance_detector_core_test.sv
// Self-checking testbench for the swing support/resistance detector core.
module swing_support_resistance_detector_core_test
    import ssrd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SEARCH_N   = 10;
    localparam int unsigned AVG_N      = 5;
    localparam int unsigned SEEN_MAX   = 10;       // max(SEARCH_N, AVG_N, 3)
    localparam longint     AVG_SCALE   = 60;       // lcm of 1..AVG_N
    localparam int         RANDOM_N    = 1100;
    localparam int         CALM_FIRST  = 400;
    localparam int         CALM_LAST   = 600;
    localparam int         HOLD_AT     = 200;
    localparam int         HOLD_CYCLES = 300;
    localparam int         DRAIN_MAX   = 20000;

    // One expected result transaction
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [PRICE_W-1:0] price;
        logic [PRICE_W-1:0] tm;
    } level_entry_t;

    // One row of the directed table
    typedef struct {
        logic [31:0]        open_p;
        logic [31:0]        close_p;
        logic [31:0]        tm;
        bit                 fixed;      // use the typed-in result below
        logic [KIND_W-1:0]  kind;
        logic [31:0]        price;
        logic [31:0]        when;
    } candle_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // open_price, close_price, candle_time
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // level_price, level_time
    logic [1:0]  m_tuser;   // event_kind

    swing_support_resistance_detector_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Predictor state
    logic [31:0] top_win    [SEARCH_N];
    logic [31:0] bottom_win [SEARCH_N];
    logic [31:0] time_win   [SEARCH_N];
    logic [31:0] close_win  [AVG_N];
    longint      slope_win  [AVG_N];
    int unsigned seen_cnt;
    longint      prev_avg;
    longint      prev_slope_sum;

    level_entry_t pending_levels[$];
    level_entry_t got_entry;
    int           errors;
    bit           calm;
    bit           hold_req;
    int           hold_left;

    // Random walk state for the random candles
    logic [31:0] walk_level;
    logic [31:0] walk_time;
    bit          walk_up;
    int          walk_left;
    int unsigned walk_step_max;

    candle_row_t directed_candles[] = '{
        '{32'd100, 32'd200, 32'd1000, 1'b1, EV_NONE, 32'd0, 32'd0},
        '{32'd300, 32'd250, 32'd1060, 1'b1, EV_NONE, 32'd0, 32'd0},
        '{32'd260, 32'd150, 32'd1120, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd150, 32'd100, 32'd1180, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd100, 32'd50,  32'd1240, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd50,  32'd60,  32'd1300, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd60,  32'd400, 32'd1360, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd400, 32'd400, 32'd1420, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd400, 32'd400, 32'd1480, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd400, 32'd400, 32'd1540, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd400, 32'd400, 32'd1600, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd400, 32'd400, 32'd1660, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd400, 32'd400, 32'd1720, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd0,   32'd0,   32'd0,    1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd0, 32'hFFFF_FFFF, 32'd1, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd3, 1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd10,  32'd5,   32'd4,    1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd5,   32'd10,  32'd5,    1'b0, EV_NONE, 32'd0, 32'd0},
        '{32'd7,   32'd7,   32'd6,    1'b0, EV_NONE, 32'd0, 32'd0}
    };

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Count and print one mismatch
    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t: mismatch: %s", $time, msg);
    endtask

    // Advance the swing state by one candle and return the expected result
    function automatic level_entry_t predict_level(input logic [31:0] open_p,
                                                   input logic [31:0] close_p,
                                                   input logic [31:0] tm);
        level_entry_t res;
        int unsigned  before_cnt;
        int unsigned  n;
        int unsigned  navg;
        int unsigned  depth;
        logic [63:0]  close_sum;
        longint       scaled;
        longint       slope_sum;
        bit           up;
        bit           down;
        logic [31:0]  best;
        logic [31:0]  best_t;

        res.kind  = EV_NONE;
        res.price = '0;
        res.tm    = '0;
        before_cnt = seen_cnt;
        n = (seen_cnt + 1 > SEEN_MAX) ? SEEN_MAX : seen_cnt + 1;

        // Shift the candle and close windows, newest at index 0
        for (int i = SEARCH_N - 1; i > 0; i--)
        begin
            top_win[i]    = top_win[i-1];
            bottom_win[i] = bottom_win[i-1];
            time_win[i]   = time_win[i-1];
        end
        for (int i = AVG_N - 1; i > 0; i--)
            close_win[i] = close_win[i-1];
        top_win[0]    = (close_p <= open_p) ? open_p : close_p;
        bottom_win[0] = (close_p <= open_p) ? close_p : open_p;
        time_win[0]   = tm;
        close_win[0]  = close_p;

        // Scaled moving average, exact during warm-up
        navg = (n < AVG_N) ? n : AVG_N;
        close_sum = '0;
        for (int i = 0; i < AVG_N; i++)
            close_sum += 64'(close_win[i]);
        scaled = longint'((close_sum * 64'(AVG_SCALE)) / 64'(navg));

        if (before_cnt >= 1)
        begin
            for (int i = AVG_N - 1; i > 0; i--)
                slope_win[i] = slope_win[i-1];
            slope_win[0] = scaled - prev_avg;
            slope_sum = 0;
            for (int i = 0; i < AVG_N; i++)
                slope_sum += slope_win[i];

            // Strict sign change of the slope sum
            if (before_cnt >= 2)
            begin
                up   = (prev_slope_sum < 0) && (slope_sum > 0);
                down = (prev_slope_sum > 0) && (slope_sum < 0);
                if (up || down)
                begin
                    depth  = (n < SEARCH_N) ? n : SEARCH_N;
                    best   = up ? bottom_win[0] : top_win[0];
                    best_t = time_win[0];
                    for (int i = 1; i < depth; i++)
                    begin
                        if (up ? (bottom_win[i] < best) : (top_win[i] > best))
                        begin
                            best   = up ? bottom_win[i] : top_win[i];
                            best_t = time_win[i];
                        end
                    end
                    res.kind  = up ? EV_SUPPORT : EV_RESISTANCE;
                    res.price = best;
                    res.tm    = best_t;
                end
            end
            prev_slope_sum = slope_sum;
        end

        prev_avg = scaled;
        seen_cnt = n;
        return res;
    endfunction

    // Offer one candle, wait for acceptance, then maybe idle
    task automatic push_candle(input logic [31:0] open_p, input logic [31:0] close_p,
                               input logic [31:0] tm, input bit fixed,
                               input level_entry_t typed);
        level_entry_t exp_res;
        int           gap;

        s_tvalid <= 1'b1;
        s_tdata  <= {tm, close_p, open_p};
        do
            @(posedge clk);
        while (!s_tready);

        exp_res = predict_level(open_p, close_p, tm);
        pending_levels.insert(pending_levels.size(), fixed ? typed : exp_res);

        gap = 0;
        if (!calm && ($urandom_range(99) < 50))
            gap = $urandom_range(1, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Build one random candle: mostly trending runs, some noise
    task automatic random_candle(output logic [31:0] open_p, output logic [31:0] close_p,
                                 output logic [31:0] tm);
        int unsigned r;
        int unsigned step;
        int unsigned spread;

        r = $urandom_range(99);
        if (r < 8)
        begin
            open_p  = $urandom;
            close_p = $urandom;
            tm      = $urandom;
            return;
        end

        // Occasionally jump the level somewhere new, extremes included
        if (r < 12)
        begin
            case ($urandom_range(2))
                0: walk_level = 32'd0;
                1: walk_level = 32'hFFFF_FFFF;
                default: walk_level = $urandom;
            endcase
        end

        // New trend run: direction and step size
        if (walk_left == 0)
        begin
            walk_up   = ($urandom_range(3) == 0) ? walk_up : ~walk_up;
            walk_left = $urandom_range(1, 6);
            case ($urandom_range(3))
                0: walk_step_max = 3;
                1: walk_step_max = 1000;
                2: walk_step_max = 100000;
                default: walk_step_max = 32'h1000_0000;
            endcase
        end
        walk_left--;

        step = ($urandom_range(9) == 0) ? 0 : $urandom_range(walk_step_max);
        walk_level = walk_up ? walk_level + step : walk_level - step;
        close_p = walk_level;

        spread = $urandom_range(walk_step_max);
        case ($urandom_range(2))
            0: open_p = close_p;
            1: open_p = close_p + spread;
            default: open_p = close_p - spread;
        endcase

        walk_time = walk_time + $urandom_range(1, 120);
        tm = walk_time;
    endtask

    // Receiver: random stalls, calm stretch, one long hold-off
    initial
    begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 33);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_levels.size() == 0)
                report_mismatch($sformatf("unexpected result kind=%0d price=%0h time=%0h",
                                          m_tuser, m_tdata[31:0], m_tdata[63:32]));
            else
            begin
                got_entry = pending_levels.pop_front();
                if (m_tuser !== got_entry.kind)
                    report_mismatch($sformatf("event_kind got %0d expected %0d",
                                              m_tuser, got_entry.kind));
                if (m_tdata[31:0] !== got_entry.price)
                    report_mismatch($sformatf("level_price got %0h expected %0h",
                                              m_tdata[31:0], got_entry.price));
                if (m_tdata[63:32] !== got_entry.tm)
                    report_mismatch($sformatf("level_time got %0h expected %0h",
                                              m_tdata[63:32], got_entry.tm));
            end
        end
    end

    // Stimulus and end of test
    initial
    begin
        level_entry_t typed;
        logic [31:0]  o;
        logic [31:0]  c;
        logic [31:0]  t;
        int           drain;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        errors   = 0;
        calm     = 1'b0;
        hold_req = 1'b0;
        seen_cnt = 0;
        prev_avg = 0;
        prev_slope_sum = 0;
        for (int i = 0; i < SEARCH_N; i++)
        begin
            top_win[i]    = '0;
            bottom_win[i] = '0;
            time_win[i]   = '0;
        end
        for (int i = 0; i < AVG_N; i++)
        begin
            close_win[i] = '0;
            slope_win[i] = 0;
        end
        walk_level    = 32'd50000;
        walk_time     = 32'd2000;
        walk_up       = 1'b1;
        walk_left     = 0;
        walk_step_max = 3;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (directed_candles[i])
        begin
            typed.kind  = directed_candles[i].kind;
            typed.price = directed_candles[i].price;
            typed.tm    = directed_candles[i].when;
            push_candle(directed_candles[i].open_p, directed_candles[i].close_p,
                        directed_candles[i].tm, directed_candles[i].fixed, typed);
        end

        // Random candles
        for (int k = 0; k < RANDOM_N; k++)
        begin
            if (k == HOLD_AT)
                hold_req = 1'b1;
            calm = (k >= CALM_FIRST) && (k < CALM_LAST);
            random_candle(o, c, t);
            push_candle(o, c, t, 1'b0, typed);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        drain = 0;
        while ((pending_levels.size() != 0) && (drain < DRAIN_MAX))
        begin
            @(posedge clk);
            drain++;
        end
        repeat (50) @(posedge clk);
        if (pending_levels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_levels.size()));

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
